// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed: label");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, rstn, expr)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- hw/rtl/esdp_pkg.sv -----
// ----------------------------------------------------------------------------
// esdp_pkg
// Types and constants of the ES descriptor parser.
// ----------------------------------------------------------------------------
`default_nettype none

package esdp_pkg;

    localparam logic [7:0] TAG_ES_DESCR   = 8'h03;
    localparam logic [7:0] TAG_DEC_CONFIG = 8'h04;
    localparam logic [7:0] OBJ_TYPE_MAX   = 8'h6A;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TRUNCATED  = 3'd1;
    localparam logic [2:0] ST_NOT_ES     = 3'd2;
    localparam logic [2:0] ST_URL        = 3'd3;
    localparam logic [2:0] ST_OBJ_RANGE  = 3'd4;
    localparam logic [2:0] ST_BAD_DC_TAG = 3'd5;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_FLAGS,
        PH_ES_TAG,
        PH_ES_LEN,
        PH_ESID,
        PH_ESFLAGS,
        PH_DEPID,
        PH_DC_TAG,
        PH_DC_LEN,
        PH_OBJ,
        PH_STYPE,
        PH_BUF,
        PH_MAXR,
        PH_AVGR,
        PH_DSI_TAG,
        PH_DSI_LEN,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       box_start;
        logic       box_last;
    } esdp_in_t;

    typedef struct packed {
        logic [15:0] es_id;
        logic        depends_flag;
        logic [15:0] depends_on_id;
        logic [4:0]  stream_priority;
        logic [7:0]  object_type;
        logic [5:0]  stream_kind;
        logic        up_stream;
        logic [23:0] buffer_size;
        logic [31:0] max_rate;
        logic [31:0] avg_rate;
        logic [27:0] specific_info_size;
    } esdp_fields_t;

    typedef struct packed {
        logic [2:0]   status;
        esdp_fields_t fields;
    } esdp_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/es_descriptor_parser_core.sv -----
// ----------------------------------------------------------------------------
// es_descriptor_parser_core
// Byte-serial parser for the payload of an elementary stream descriptor box.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one payload byte per transaction with its
//   box_start (first byte, the version byte) and box_last markers.
//   m_valid/m_ready/m_data carry one result transaction per box_last byte:
//   a status code plus every descriptor field parsed so far (unparsed = 0).
//   The result is in the output register in the cycle after the box_last
//   byte is accepted. Throughput: one byte per cycle while no box_last
//   byte waits; each byte advances the field state machine by one step.
//   Stall: bytes without box_last are always taken, since they produce no
//   result. A box_last byte waits only while the previous result sits in
//   the output register and m_ready is low.
//   Reset (aresetn low, synchronous): the parser waits for box_start with all
//   held fields cleared, and the output register is empty.
//   Bytes outside a box are ignored; box_last there gives status truncated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module es_descriptor_parser_core (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire esdp_pkg::esdp_in_t  s_data,
    output logic                     m_valid,
    input  wire                      m_ready,
    output esdp_pkg::esdp_out_t      m_data
);
    import esdp_pkg::*;

    // parser state
    phase_t       phase_reg,     phase_next;
    logic [2:0]   fcnt_reg,      fcnt_next;     // bytes of current fixed field
    logic [27:0]  acc_reg,       acc_next;      // expandable size accumulator
    logic [2:0]   scnt_reg,      scnt_next;     // bytes of current size
    logic         url_reg,       url_next;
    logic [2:0]   status_reg,    status_next;
    esdp_fields_t held_reg,      held_next;

    // output register
    logic         m_valid_reg,   m_valid_next;
    esdp_out_t    m_data_reg,    m_data_next;

    logic         s_accept;
    logic [7:0]   b;
    logic [27:0]  acc_shift;
    logic         size_done;
    logic         stop;
    logic [2:0]   stop_status;

    assign b         = s_data.data_byte;
    assign acc_shift = {acc_reg[20:0], b[6:0]};
    // size ends on a clear continuation bit or on its fourth byte
    assign size_done = !b[7] || (scnt_reg >= 3'd3);

    // a byte that closes no box can go in even while a result waits
    assign s_ready  = !m_valid_reg || m_ready || !s_data.box_last;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // one step of the field state machine
    always_comb begin
        phase_next  = phase_reg;
        fcnt_next   = fcnt_reg;
        acc_next    = acc_reg;
        scnt_next   = scnt_reg;
        url_next    = url_reg;
        status_next = status_reg;
        held_next   = held_reg;
        stop        = 1'b0;
        stop_status = ST_OK;

        if (s_data.box_start) begin
            phase_next  = PH_FLAGS;
            fcnt_next   = '0;
            acc_next    = '0;
            scnt_next   = '0;
            url_next    = 1'b0;
            status_next = ST_OK;
            held_next   = '0;
        end else begin
            unique case (phase_reg)
                PH_FLAGS: begin
                    if (fcnt_reg >= 3'd2) begin
                        fcnt_next  = '0;
                        phase_next = PH_ES_TAG;
                    end else begin
                        fcnt_next = fcnt_reg + 3'd1;
                    end
                end
                PH_ES_TAG: begin
                    if (b != TAG_ES_DESCR) begin
                        stop        = 1'b1;
                        stop_status = ST_NOT_ES;
                    end else begin
                        acc_next   = '0;
                        scnt_next  = '0;
                        phase_next = PH_ES_LEN;
                    end
                end
                PH_ES_LEN: begin
                    acc_next  = acc_shift;
                    scnt_next = scnt_reg + 3'd1;
                    if (size_done) begin
                        fcnt_next  = '0;
                        phase_next = PH_ESID;
                    end
                end
                PH_ESID: begin
                    held_next.es_id = {held_reg.es_id[7:0], b};
                    if (fcnt_reg >= 3'd1) begin
                        fcnt_next  = '0;
                        phase_next = PH_ESFLAGS;
                    end else begin
                        fcnt_next = fcnt_reg + 3'd1;
                    end
                end
                PH_ESFLAGS: begin
                    held_next.depends_flag    = b[7];
                    held_next.stream_priority = b[4:0];
                    url_next                  = b[6];
                    if (b[7]) begin
                        fcnt_next  = '0;
                        phase_next = PH_DEPID;
                    end else if (b[6]) begin
                        stop        = 1'b1;
                        stop_status = ST_URL;
                    end else begin
                        phase_next = PH_DC_TAG;
                    end
                end
                PH_DEPID: begin
                    held_next.depends_on_id = {held_reg.depends_on_id[7:0], b};
                    if (fcnt_reg >= 3'd1) begin
                        fcnt_next = '0;
                        if (url_reg) begin
                            stop        = 1'b1;
                            stop_status = ST_URL;
                        end else begin
                            phase_next = PH_DC_TAG;
                        end
                    end else begin
                        fcnt_next = fcnt_reg + 3'd1;
                    end
                end
                PH_DC_TAG: begin
                    if (b != TAG_DEC_CONFIG) begin
                        stop        = 1'b1;
                        stop_status = ST_BAD_DC_TAG;
                    end else begin
                        acc_next   = '0;
                        scnt_next  = '0;
                        phase_next = PH_DC_LEN;
                    end
                end
                PH_DC_LEN: begin
                    acc_next  = acc_shift;
                    scnt_next = scnt_reg + 3'd1;
                    if (size_done) begin
                        phase_next = PH_OBJ;
                    end
                end
                PH_OBJ: begin
                    held_next.object_type = b;
                    if (b > OBJ_TYPE_MAX) begin
                        stop        = 1'b1;
                        stop_status = ST_OBJ_RANGE;
                    end else begin
                        phase_next = PH_STYPE;
                    end
                end
                PH_STYPE: begin
                    held_next.stream_kind = b[7:2];
                    held_next.up_stream   = b[1];
                    fcnt_next             = '0;
                    phase_next            = PH_BUF;
                end
                PH_BUF: begin
                    held_next.buffer_size = {held_reg.buffer_size[15:0], b};
                    if (fcnt_reg >= 3'd2) begin
                        fcnt_next  = '0;
                        phase_next = PH_MAXR;
                    end else begin
                        fcnt_next = fcnt_reg + 3'd1;
                    end
                end
                PH_MAXR: begin
                    held_next.max_rate = {held_reg.max_rate[23:0], b};
                    if (fcnt_reg >= 3'd3) begin
                        fcnt_next  = '0;
                        phase_next = PH_AVGR;
                    end else begin
                        fcnt_next = fcnt_reg + 3'd1;
                    end
                end
                PH_AVGR: begin
                    held_next.avg_rate = {held_reg.avg_rate[23:0], b};
                    if (fcnt_reg >= 3'd3) begin
                        fcnt_next  = '0;
                        phase_next = PH_DSI_TAG;
                    end else begin
                        fcnt_next = fcnt_reg + 3'd1;
                    end
                end
                PH_DSI_TAG: begin
                    // tag value is not checked
                    acc_next   = '0;
                    scnt_next  = '0;
                    phase_next = PH_DSI_LEN;
                end
                PH_DSI_LEN: begin
                    acc_next  = acc_shift;
                    scnt_next = scnt_reg + 3'd1;
                    if (size_done) begin
                        held_next.specific_info_size = acc_shift;
                        stop                         = 1'b1;
                        stop_status                  = ST_OK;
                    end
                end
                default: begin
                    // idle and done: byte ignored
                end
            endcase
        end

        if (stop) begin
            status_next = stop_status;
            phase_next  = PH_DONE;
        end

        // result for a box_last byte; parser then clears and waits
        m_data_next.status = (phase_next == PH_DONE) ? status_next : ST_TRUNCATED;
        m_data_next.fields = held_next;
        if (s_data.box_last) begin
            phase_next  = PH_IDLE;
            fcnt_next   = '0;
            acc_next    = '0;
            scnt_next   = '0;
            url_next    = 1'b0;
            status_next = ST_OK;
            held_next   = '0;
        end

        m_valid_next = m_valid_reg;
        if (s_accept && s_data.box_last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            fcnt_reg    <= '0;
            acc_reg     <= '0;
            scnt_reg    <= '0;
            url_reg     <= 1'b0;
            status_reg  <= ST_OK;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg  <= phase_next;
                fcnt_reg   <= fcnt_next;
                acc_reg    <= acc_next;
                scnt_reg   <= scnt_next;
                url_reg    <= url_next;
                status_reg <= status_next;
                held_reg   <= held_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, loaded only when a transaction closes a box
    always_ff @(posedge aclk) begin
        if (s_accept && s_data.box_last) begin
            m_data_reg <= m_data_next;
        end
    end

    // ---------------------------------------------------------------- checks
    `ASSERT_NEXT(a_last_idles, aclk, aresetn, s_accept && s_data.box_last, phase_reg == PH_IDLE && held_reg == '0)
    `ASSERT_NEXT(a_start_flags, aclk, aresetn, s_accept && s_data.box_start && !s_data.box_last, phase_reg == PH_FLAGS)
    `ASSERT_ALWAYS(a_status_range, aclk, aresetn, !m_valid_reg || m_data_reg.status <= ST_BAD_DC_TAG)
    `ASSERT_ALWAYS(a_size_count, aclk, aresetn, scnt_reg <= 3'd4)

endmodule

`default_nettype wire
